/* rtl/brb_pkg.sv */
// ----------------------------------------------------------------------------
// brb_pkg: shared types and constants for the byte ring buffer
// Item and result layouts, action codes, the internal command format and
// the back-end state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package brb_pkg;

   // Buffer geometry
   localparam int CAPACITY  = 1024;
   localparam int MAX_BLOCK = 64;
   localparam int IDX_W     = 10;   // index into the byte store
   localparam int CNT_W     = 11;   // fill count, holds CAPACITY itself
   localparam int LEN_W     = 7;

   // Action codes carried on the request channel
   localparam logic [2:0] ACT_WRITE  = 3'd0;
   localparam logic [2:0] ACT_READ   = 3'd1;
   localparam logic [2:0] ACT_PEEK   = 3'd2;
   localparam logic [2:0] ACT_REMOVE = 3'd3;
   localparam logic [2:0] ACT_QUERY  = 3'd4;

   // Status codes
   localparam logic STAT_OK   = 1'b0;
   localparam logic STAT_FAIL = 1'b1;

   typedef struct packed {
      logic [2:0]       action;
      logic [LEN_W-1:0] block_length;
      logic [7:0]       data_byte;
      logic             clear_counter;
   } req_item_type;

   typedef struct packed {
      logic             status;
      logic [7:0]       out_byte;
      logic             last;
      logic [CNT_W-1:0] fill_level;
      logic [CNT_W-1:0] free_space;
      logic [CNT_W-1:0] contiguous_length;
      logic [IDX_W-1:0] read_position;
      logic [63:0]      bytes_written;
   } rsp_item_type;

   typedef enum logic [2:0] {
      CMD_WRITE,
      CMD_READ,
      CMD_PEEK,
      CMD_REMOVE,
      CMD_QUERY
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [LEN_W-1:0] len;
      logic [7:0]       data;
      logic             clear;
   } cmd_type;

   // Head of the command queue as seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_head_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_STREAM
   } back_state_type;

endpackage

`default_nettype wire

/* rtl/brb_front.sv */
// ----------------------------------------------------------------------------
// brb_front: request intake and command queue
// Accepts request transfers, decodes the action into a command, drops
// unknown actions and holds up to two commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_front import brb_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output      logic         busy,
   input  wire req_item_type req_item,
   output      cmd_head_type cmd_head,
   input  wire logic         cmd_pop
);

   cmd_type    queue_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       accept;
   logic       known;
   logic       push;
   logic       pop;
   cmd_type    decoded;

   // Decode the action into a command kind
   always_comb begin
      decoded.len   = req_item.block_length;
      decoded.data  = req_item.data_byte;
      decoded.clear = req_item.clear_counter;
      decoded.kind  = CMD_WRITE;
      known         = 1'b1;
      case (req_item.action)
         ACT_WRITE:  decoded.kind = CMD_WRITE;
         ACT_READ:   decoded.kind = CMD_READ;
         ACT_PEEK:   decoded.kind = CMD_PEEK;
         ACT_REMOVE: decoded.kind = CMD_REMOVE;
         ACT_QUERY:  decoded.kind = CMD_QUERY;
         default:    known        = 1'b0;
      endcase
   end

   assign busy   = (count_ff == 2'd2);
   assign accept = start && !busy;
   assign push   = accept && known;
   assign pop    = cmd_pop && (count_ff != 2'd0);

   // Advance queue pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Store the decoded command
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

   assign cmd_head.valid = (count_ff != 2'd0);
   assign cmd_head.cmd   = queue_ff[rd_ptr_ff];

endmodule

`default_nettype wire

/* rtl/brb_back.sv */
// ----------------------------------------------------------------------------
// brb_back: command execution and byte store
// Runs one command at a time against the ring buffer state. Single-result
// commands finish in the idle state; read and peek stream one byte per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_back import brb_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cmd_head_type cmd_head,
   output      logic         cmd_pop,
   output      logic         rsp_strobe,
   output      rsp_item_type rsp_item
);

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(CAPACITY - 1);
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BLOCK);

   logic [7:0]       mem [CAPACITY];

   back_state_type   state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [63:0]      total_ff, total_in;
   logic [LEN_W-1:0] wr_rem_ff, wr_rem_in;
   logic             wr_drop_ff, wr_drop_in;
   logic [IDX_W-1:0] stream_idx_ff, stream_idx_in;
   logic [LEN_W-1:0] stream_left_ff, stream_left_in;
   logic             one_strobe_ff, one_strobe_in;
   rsp_item_type     one_item_ff, one_item_in;
   logic             rd_valid_ff, rd_valid_in;
   logic             rd_last_ff, rd_last_in;
   logic [7:0]       rd_data_ff;
   logic             mem_wr_en;
   logic             mem_rd_en;

   cmd_type          cmd;
   logic [CNT_W-1:0] len_ext;
   logic [CNT_W-1:0] fit_sum;
   logic [CNT_W-1:0] head_sum;
   logic [CNT_W-1:0] head_wrap;
   logic [CNT_W-1:0] count_less;
   logic [CNT_W-1:0] contig_sum;
   logic [LEN_W-1:0] eff_rem;
   logic             eff_drop;
   logic             fetch_fail;

   assign cmd        = cmd_head.cmd;
   assign len_ext    = CNT_W'(cmd.len);
   assign fit_sum    = count_ff + len_ext;
   assign head_sum   = CNT_W'(head_ff) + len_ext;
   assign head_wrap  = (head_sum >= CAP_CNT) ? head_sum - CAP_CNT : head_sum;
   assign count_less = count_ff - len_ext;
   assign contig_sum = CNT_W'(head_ff) + count_ff;
   assign fetch_fail = (cmd.len > MAX_LEN) || (len_ext > count_ff);

   // Write block bookkeeping: a new block starts when nothing is due
   always_comb begin
      if (wr_rem_ff == '0) begin
         eff_rem  = cmd.len;
         eff_drop = (cmd.len > MAX_LEN) || (fit_sum > CAP_CNT);
      end else begin
         eff_rem  = wr_rem_ff;
         eff_drop = wr_drop_ff;
      end
   end

   // Execute the head command or stream bytes
   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      total_in       = total_ff;
      wr_rem_in      = wr_rem_ff;
      wr_drop_in     = wr_drop_ff;
      stream_idx_in  = stream_idx_ff;
      stream_left_in = stream_left_ff;
      one_strobe_in  = 1'b0;
      one_item_in    = '0;
      one_item_in.last = 1'b1;
      rd_valid_in    = 1'b0;
      rd_last_in     = 1'b0;
      mem_wr_en      = 1'b0;
      mem_rd_en      = 1'b0;
      cmd_pop        = 1'b0;

      case (state_ff)
         BACK_IDLE: begin
            if (cmd_head.valid) begin
               cmd_pop       = 1'b1;
               one_strobe_in = 1'b1;
               case (cmd.kind)
                  CMD_WRITE: begin
                     if (wr_rem_ff == '0 && cmd.len == '0) begin
                        one_item_in.status = STAT_OK;
                     end else begin
                        if (wr_rem_ff == '0 && !eff_drop) begin
                           total_in = total_ff + 64'(cmd.len);
                        end
                        wr_rem_in  = eff_rem - LEN_W'(1);
                        wr_drop_in = eff_drop;
                        if (eff_drop || count_ff >= CAP_CNT) begin
                           one_item_in.status = STAT_FAIL;
                           if (eff_rem == LEN_W'(1)) begin
                              wr_drop_in = 1'b0;
                           end
                        end else begin
                           one_item_in.status = STAT_OK;
                           mem_wr_en = 1'b1;
                           tail_in   = (tail_ff == IDX_TOP) ? '0 : tail_ff + IDX_W'(1);
                           count_in  = count_ff + CNT_W'(1);
                        end
                     end
                  end
                  CMD_READ, CMD_PEEK, CMD_REMOVE: begin
                     if (fetch_fail) begin
                        one_item_in.status = STAT_FAIL;
                     end else begin
                        one_item_in.status = STAT_OK;
                        if (cmd.kind != CMD_REMOVE && cmd.len != '0) begin
                           // hand over to the byte stream
                           one_strobe_in  = 1'b0;
                           stream_idx_in  = head_ff;
                           stream_left_in = cmd.len;
                           state_in       = BACK_STREAM;
                        end
                        if (cmd.kind != CMD_PEEK) begin
                           count_in = count_less;
                           head_in  = head_wrap[IDX_W-1:0];
                           if (count_less == '0) begin
                              head_in = '0;
                              tail_in = '0;
                           end
                        end
                     end
                  end
                  CMD_QUERY: begin
                     one_item_in.status            = STAT_OK;
                     one_item_in.fill_level        = count_ff;
                     one_item_in.free_space        = CAP_CNT - count_ff;
                     one_item_in.contiguous_length = (contig_sum > CAP_CNT)
                                                     ? CAP_CNT - CNT_W'(head_ff) : count_ff;
                     one_item_in.read_position     = head_ff;
                     one_item_in.bytes_written     = total_ff;
                     if (cmd.clear) begin
                        total_in = '0;
                     end
                  end
                  default: begin
                     one_strobe_in = 1'b0;
                  end
               endcase
            end
         end
         BACK_STREAM: begin
            mem_rd_en      = 1'b1;
            rd_valid_in    = 1'b1;
            rd_last_in     = (stream_left_ff == LEN_W'(1));
            stream_idx_in  = (stream_idx_ff == IDX_TOP) ? '0 : stream_idx_ff + IDX_W'(1);
            stream_left_in = stream_left_ff - LEN_W'(1);
            if (stream_left_ff == LEN_W'(1)) begin
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BACK_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         total_ff      <= '0;
         wr_rem_ff     <= '0;
         wr_drop_ff    <= 1'b0;
         one_strobe_ff <= 1'b0;
         rd_valid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         total_ff      <= total_in;
         wr_rem_ff     <= wr_rem_in;
         wr_drop_ff    <= wr_drop_in;
         one_strobe_ff <= one_strobe_in;
         rd_valid_ff   <= rd_valid_in;
      end
   end

   // Hold payload and stream registers
   always_ff @(posedge clock) begin
      stream_idx_ff  <= stream_idx_in;
      stream_left_ff <= stream_left_in;
      one_item_ff    <= one_item_in;
      rd_last_ff     <= rd_last_in;
   end

   // Byte store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[tail_ff] <= cmd.data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= mem[stream_idx_ff];
      end
   end

   // Select the streamed byte or the single result
   always_comb begin
      rsp_strobe = one_strobe_ff || rd_valid_ff;
      rsp_item   = one_item_ff;
      if (rd_valid_ff) begin
         rsp_item          = '0;
         rsp_item.status   = STAT_OK;
         rsp_item.out_byte = rd_data_ff;
         rsp_item.last     = rd_last_ff;
      end
   end

endmodule

`default_nettype wire

/* rtl/byte_ring_buffer_block_access.sv */
// ----------------------------------------------------------------------------
// byte_ring_buffer_block_access: 1024-byte ring buffer with block access
// Top level: command queue front end feeding the execution back end.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_item and raise start; the transfer happens on a clock edge
//   where start is high and busy is low. busy rises while the two-entry
//   command queue is full. Unknown actions are taken and dropped.
//   Each result appears on rsp_item for one cycle with rsp_strobe high;
//   the receiver cannot stall, so it must take every strobe.
//   rsp_item.last marks the final result of a request.
// Timing:
//   A request passes through the command queue and the back end, whose result
//   registers drive the result port. Write, remove, query and failed requests
//   finish without streaming, so a stream of them runs at one per cycle.
//   A read or peek of N bytes first takes the command, then emits one byte
//   per cycle; the single read port of the byte store sets that pace.
// Reset:
//   Synchronous reset empties the buffer, zeroes both indices and the
//   written-byte counter, ends any write block and flushes the queue.
//   Store contents are not cleared; only stored bytes are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_buffer_block_access import brb_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output      logic         busy,
   input  wire req_item_type req_item,
   output      logic         rsp_strobe,
   output      rsp_item_type rsp_item
);

   cmd_head_type cmd_head;
   logic         cmd_pop;

   brb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .cmd_head (cmd_head),
      .cmd_pop  (cmd_pop)
   );

   brb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_head   (cmd_head),
      .cmd_pop    (cmd_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // A failure is always the only result of its request
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status == STAT_FAIL) |-> rsp_item.last)
      else $error("failure result without last");

   // Only successful reads carry a data byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.out_byte != 8'd0) |-> (rsp_item.status == STAT_OK))
      else $error("data byte on a failed result");

   // Fill level and free space of a status report add up to the capacity
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_item.fill_level != '0 || rsp_item.free_space != '0))
      |-> (({1'b0, rsp_item.fill_level} + {1'b0, rsp_item.free_space})
           == (CNT_W + 1)'(CAPACITY)))
      else $error("fill level and free space disagree");

endmodule

`default_nettype wire

/* tb/sv/tb_byte_ring_buffer_block_access.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_ring_buffer_block_access: self-checking bench for the byte ring buffer
// Drives directed and random request streams through the start/busy port,
// tracks the buffer contents in a local model and checks every strobed result
// field by field, in order, against the model's expected results.
// ----------------------------------------------------------------------------

module tb_byte_ring_buffer_block_access;
   import brb_pkg::*;

   // Action codes the block takes and drops without a result
   localparam logic [2:0] ACT_RSVD_FIRST = 3'd5;
   localparam logic [2:0] ACT_RSVD_LAST  = 3'd7;
   localparam int MAX_SHOWN = 10;
   localparam int REQ_W     = $bits(req_item_type);

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_item_type req_item = '0;
   logic         rsp_strobe;
   rsp_item_type rsp_item;

   // Local copy of the buffer state
   logic [7:0]  ring_mem [CAPACITY];
   int unsigned ring_head = 0;
   int unsigned ring_tail = 0;
   int unsigned ring_fill = 0;
   logic [63:0] ring_written = '0;
   int unsigned blk_left = 0;
   logic        blk_dropping = 1'b0;

   rsp_item_type due_results [$];
   rsp_item_type oldest_due;
   int          err_count = 0;
   int          sender_idle_pct = 0;

   byte_ring_buffer_block_access DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Work out the results of one accepted request and advance the buffer state
   task automatic compute_ring_results(input req_item_type it);
      rsp_item_type r;
      int unsigned  len;
      int unsigned  idx;
      r = '0;
      r.last = 1'b1;
      r.status = STAT_OK;
      len = 32'(it.block_length);
      case (it.action)
         ACT_WRITE: begin
            if (blk_left == 0 && len == 0) begin
               due_results.push_back(r);
            end else begin
               // open a block: reserve space or drop the whole block
               if (blk_left == 0) begin
                  blk_left = len;
                  if (len > MAX_BLOCK || ring_fill + len > CAPACITY) begin
                     blk_dropping = 1'b1;
                  end else begin
                     blk_dropping = 1'b0;
                     ring_written += 64'(len);
                  end
               end
               blk_left--;
               if (blk_dropping || ring_fill >= CAPACITY) begin
                  if (blk_left == 0) blk_dropping = 1'b0;
                  r.status = STAT_FAIL;
               end else begin
                  ring_mem[IDX_W'(ring_tail)] = it.data_byte;
                  ring_tail = (ring_tail + 1) % CAPACITY;
                  ring_fill++;
               end
               due_results.push_back(r);
            end
         end
         ACT_READ, ACT_PEEK, ACT_REMOVE: begin
            if (len > MAX_BLOCK || len > ring_fill) begin
               r.status = STAT_FAIL;
               due_results.push_back(r);
            end else begin
               // emit bytes oldest first, one result each
               if (it.action != ACT_REMOVE && len > 0) begin
                  idx = ring_head;
                  for (int i = 0; i < len; i++) begin
                     r.out_byte = ring_mem[IDX_W'(idx)];
                     r.last = (i + 1 == len);
                     due_results.push_back(r);
                     idx = (idx + 1) % CAPACITY;
                  end
               end else begin
                  due_results.push_back(r);
               end
               // consume, and rewind both indices once empty
               if (it.action != ACT_PEEK) begin
                  ring_head = (ring_head + len) % CAPACITY;
                  ring_fill -= len;
                  if (ring_fill == 0) begin
                     ring_head = 0;
                     ring_tail = 0;
                  end
               end
            end
         end
         ACT_QUERY: begin
            r.fill_level = CNT_W'(ring_fill);
            r.free_space = CNT_W'(CAPACITY - ring_fill);
            r.contiguous_length = (ring_head + ring_fill > CAPACITY)
                                  ? CNT_W'(CAPACITY - ring_head) : CNT_W'(ring_fill);
            r.read_position = IDX_W'(ring_head);
            r.bytes_written = ring_written;
            due_results.push_back(r);
            if (it.clear_counter) ring_written = '0;
         end
         default: begin
         end
      endcase
   endtask

   task automatic report_error(input string what, input logic [63:0] want,
                               input logic [63:0] got);
      err_count++;
      if (err_count <= MAX_SHOWN)
         $display("[%0t] mismatch %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
   endtask

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) report_error(what, want, got);
   endtask

   // Check each strobed result against the oldest expected one
   always @(posedge clock) begin
      if (!reset) begin
         if ($isunknown(rsp_strobe)) begin
            report_error("rsp_strobe unknown", 64'd0, 64'd1);
         end else if (rsp_strobe) begin
            if (due_results.size() == 0) begin
               report_error("unexpected result", 64'd0, 64'd1);
            end else begin
               oldest_due = due_results.pop_front();
               check_field("status", 64'(oldest_due.status), 64'(rsp_item.status));
               check_field("out_byte", 64'(oldest_due.out_byte), 64'(rsp_item.out_byte));
               check_field("last", 64'(oldest_due.last), 64'(rsp_item.last));
               check_field("fill_level", 64'(oldest_due.fill_level),
                           64'(rsp_item.fill_level));
               check_field("free_space", 64'(oldest_due.free_space),
                           64'(rsp_item.free_space));
               check_field("contiguous_length", 64'(oldest_due.contiguous_length),
                           64'(rsp_item.contiguous_length));
               check_field("read_position", 64'(oldest_due.read_position),
                           64'(rsp_item.read_position));
               check_field("bytes_written", oldest_due.bytes_written,
                           rsp_item.bytes_written);
            end
         end
      end
   end

   function automatic req_item_type mk_req(input logic [2:0] act, input int len,
                                           input logic [7:0] data, input logic clr);
      req_item_type r;
      r.action = act;
      r.block_length = LEN_W'(len);
      r.data_byte = data;
      r.clear_counter = clr;
      return r;
   endfunction

   // Hold start until the transfer, then advance to the next falling edge
   task automatic send_req(input req_item_type it);
      while ($urandom_range(99) < sender_idle_pct) begin
         start = 1'b0;
         req_item = REQ_W'($urandom);
         @(negedge clock);
      end
      start = 1'b1;
      req_item = it;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      compute_ring_results(it);
      @(negedge clock);
   endtask

   // One write block: the first item carries the length, the rest random noise there
   task automatic send_write_block(input int len);
      send_req(mk_req(ACT_WRITE, len, 8'($urandom), 1'($urandom)));
      for (int i = 1; i < len; i++)
         send_req(mk_req(ACT_WRITE, $urandom_range(127), 8'($urandom), 1'($urandom)));
   endtask

   task automatic test_small_block();
      send_req(mk_req(ACT_WRITE, 3, 8'h00, 1'b0));
      send_req(mk_req(ACT_WRITE, 0, 8'hFF, 1'b1));
      send_req(mk_req(ACT_WRITE, 127, 8'h5A, 1'b0));
      send_req(mk_req(ACT_QUERY, 0, 8'h00, 1'b0));
      send_req(mk_req(ACT_PEEK, 3, 8'h00, 1'b0));
      send_req(mk_req(ACT_READ, 2, 8'h00, 1'b0));
      send_req(mk_req(ACT_READ, 1, 8'h00, 1'b0));
      send_req(mk_req(ACT_QUERY, 0, 8'h00, 1'b0));
   endtask

   task automatic test_edge_requests();
      // shortage, zero-length and over-length requests on an empty buffer
      send_req(mk_req(ACT_READ, 1, 8'h00, 1'b0));
      send_req(mk_req(ACT_PEEK, 0, 8'h00, 1'b0));
      send_req(mk_req(ACT_REMOVE, 0, 8'h00, 1'b0));
      send_req(mk_req(ACT_READ, 0, 8'h00, 1'b0));
      send_req(mk_req(ACT_WRITE, 0, 8'hC3, 1'b0));
      send_req(mk_req(ACT_WRITE, 2, 8'hFF, 1'b0));
      send_req(mk_req(ACT_WRITE, 0, 8'h81, 1'b0));
      send_req(mk_req(ACT_READ, 127, 8'h00, 1'b1));
      send_req(mk_req(ACT_PEEK, 3, 8'h00, 1'b0));
      send_req(mk_req(ACT_QUERY, 0, 8'h00, 1'b1));
      send_req(mk_req(ACT_QUERY, 0, 8'h00, 1'b0));
      for (int a = int'(ACT_RSVD_FIRST); a <= int'(ACT_RSVD_LAST); a++)
         send_req(mk_req(3'(a), 1, 8'h00, 1'b0));
      send_req(mk_req(ACT_REMOVE, 2, 8'h00, 1'b0));
      send_req(mk_req(ACT_QUERY, 0, 8'h00, 1'b0));
   endtask

   task automatic test_interleaved_block();
      // other actions inside an open write block leave the block alone
      send_req(mk_req(ACT_WRITE, 4, 8'h11, 1'b0));
      send_req(mk_req(ACT_QUERY, 0, 8'h00, 1'b0));
      send_req(mk_req(ACT_WRITE, 0, 8'h22, 1'b0));
      send_req(mk_req(ACT_PEEK, 1, 8'h00, 1'b0));
      send_req(mk_req(ACT_WRITE, 0, 8'h33, 1'b0));
      send_req(mk_req(ACT_REMOVE, 1, 8'h00, 1'b0));
      send_req(mk_req(ACT_WRITE, 64, 8'h44, 1'b0));
      send_req(mk_req(ACT_QUERY, 0, 8'h00, 1'b0));
      send_req(mk_req(ACT_READ, 3, 8'h00, 1'b0));
   endtask

   task automatic test_capacity_and_wrap();
      // fill to the brim, then reject a block for space
      for (int b = 0; b < CAPACITY / MAX_BLOCK; b++) send_write_block(MAX_BLOCK);
      send_req(mk_req(ACT_QUERY, 0, 8'h00, 1'b0));
      send_write_block(1);
      send_req(mk_req(ACT_READ, MAX_BLOCK + 1, 8'h00, 1'b0));
      // move the head, then wrap the tail past the end of the store
      for (int b = 0; b < 3; b++) send_req(mk_req(ACT_READ, MAX_BLOCK, 8'h00, 1'b0));
      send_write_block(MAX_BLOCK);
      send_write_block(MAX_BLOCK);
      send_req(mk_req(ACT_QUERY, 0, 8'h00, 1'b0));
      send_req(mk_req(ACT_PEEK, MAX_BLOCK, 8'h00, 1'b0));
      send_req(mk_req(ACT_REMOVE, MAX_BLOCK, 8'h00, 1'b0));
      send_req(mk_req(ACT_QUERY, 0, 8'h00, 1'b1));
      // drain to empty
      while (ring_fill > 0)
         send_req(mk_req(ACT_READ, (ring_fill < MAX_BLOCK) ? ring_fill : MAX_BLOCK,
                         8'h00, 1'b0));
      send_req(mk_req(ACT_QUERY, 0, 8'h00, 1'b0));
      send_write_block(MAX_BLOCK + 1);
      send_req(mk_req(ACT_QUERY, 0, 8'h00, 1'b0));
   endtask

   // Mostly well-formed blocks and fitting fetches, with some noise
   function automatic req_item_type next_random_item();
      int unsigned roll;
      int unsigned pick;
      int unsigned top;
      int          len;
      roll = $urandom_range(99);
      top = (ring_fill < MAX_BLOCK) ? ring_fill : MAX_BLOCK;
      if (blk_left != 0) begin
         if (roll < 85)
            return mk_req(ACT_WRITE, $urandom_range(127), 8'($urandom), 1'($urandom));
         roll = $urandom_range(99, 40);
      end
      if (roll < 40) begin
         pick = $urandom_range(99);
         if (pick < 5) len = 0;
         else if (pick < 10) len = $urandom_range(127, MAX_BLOCK + 1);
         else if (pick < 25) len = $urandom_range(MAX_BLOCK, 17);
         else len = $urandom_range(16, 1);
         return mk_req(ACT_WRITE, len, 8'($urandom), 1'($urandom));
      end
      len = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(top);
      if (roll < 60) return mk_req(ACT_READ, len, 8'($urandom), 1'($urandom));
      if (roll < 72) return mk_req(ACT_PEEK, len, 8'($urandom), 1'($urandom));
      if (roll < 84) return mk_req(ACT_REMOVE, len, 8'($urandom), 1'($urandom));
      if (roll < 94)
         return mk_req(ACT_QUERY, $urandom, 8'($urandom), ($urandom_range(9) < 3));
      return mk_req(3'($urandom_range(ACT_RSVD_LAST, ACT_RSVD_FIRST)), $urandom,
                    8'($urandom), 1'($urandom));
   endfunction

   task automatic test_random_traffic(input int idle_pct, input int num_items);
      req_item_type it;
      int           sent;
      sent = 0;
      while (sent < num_items) begin
         // alternate stretches without idling and with it
         sender_idle_pct = ((sent % 25) < 8) ? 0 : idle_pct;
         it = next_random_item();
         send_req(it);
         if (it.action <= ACT_QUERY) sent++;
      end
      sender_idle_pct = 0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_small_block();
      test_edge_requests();
      test_interleaved_block();
      test_capacity_and_wrap();
      test_random_traffic(0, 100);
      test_random_traffic(80, 100);
      test_random_traffic(38, 100);
      start = 1'b0;
      // drain outstanding results, then watch for strays
      while (due_results.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (err_count == 0)
         $display("tb_byte_ring_buffer_block_access: done, clean");
      else
         $display("tb_byte_ring_buffer_block_access: done, errors");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("tb_byte_ring_buffer_block_access: done, errors");
      $finish;
   end

endmodule
